@@ hdl/aiss_pkg.sv @@
// Shared types, codes and button masks for the arcade I/O port and shifter block.
package aiss_pkg;

  typedef enum logic [1:0] {
    OP_IN     = 2'd0,
    OP_OUT    = 2'd1,
    OP_BUTTON = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] PORT_ALL_ONES = 3'd0;
  localparam logic [2:0] PORT_BTN_ONE  = 3'd1;
  localparam logic [2:0] PORT_BTN_TWO  = 3'd2;
  localparam logic [2:0] PORT_SHIFT    = 3'd3;
  localparam logic [2:0] PORT_SOUND_A  = 3'd3;
  localparam logic [2:0] PORT_SHIFT_IN = 3'd4;
  localparam logic [2:0] PORT_SOUND_B  = 3'd5;
  localparam logic [2:0] PORT_AMOUNT   = 3'd2;

  localparam logic [2:0] BTN_COIN   = 3'd0;
  localparam logic [2:0] BTN_START2 = 3'd1;
  localparam logic [2:0] BTN_START1 = 3'd2;
  localparam logic [2:0] BTN_LEFT   = 3'd3;
  localparam logic [2:0] BTN_FIRE   = 3'd4;
  localparam logic [2:0] BTN_RIGHT  = 3'd5;

  localparam logic [7:0] ALL_ONES      = 8'hff;
  localparam logic [7:0] LOOP_BIT      = 8'h01;
  localparam logic [7:0] SOUND_A_MASK  = 8'h0e;
  localparam logic [7:0] SOUND_B_MASK  = 8'h1f;
  localparam logic [3:0] SHIFT_BASE    = 4'd8;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] port;
    logic [7:0] data;
    logic [2:0] button;
    logic       pressed;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_hit;
    logic [8:0] sound_trigger;
    logic       loop_start;
    logic       loop_stop;
  } rsp_t;

  // Bits of the first button latch touched by each button.
  function automatic logic [7:0] btn_mask_one(input logic [2:0] button);
    logic [7:0] mask;
    mask = 8'h00;
    case (button)
      BTN_COIN:   mask = 8'h01;
      BTN_START2: mask = 8'h02;
      BTN_START1: mask = 8'h04;
      BTN_LEFT:   mask = 8'h20;
      BTN_FIRE:   mask = 8'h10;
      BTN_RIGHT:  mask = 8'h40;
      default:    mask = 8'h00;
    endcase
    return mask;
  endfunction

  // Only the player controls are mirrored into the second latch.
  function automatic logic [7:0] btn_mask_two(input logic [2:0] button);
    logic [7:0] mask;
    mask = 8'h00;
    case (button)
      BTN_LEFT:  mask = 8'h20;
      BTN_FIRE:  mask = 8'h10;
      BTN_RIGHT: mask = 8'h40;
      default:   mask = 8'h00;
    endcase
    return mask;
  endfunction

endpackage

@@ hdl/aiss_req_if.sv @@
// Request channel: one CPU access or button event per item.
interface aiss_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] port;
  logic [7:0] data;
  logic [2:0] button;
  logic       pressed;

  modport source (output valid, output op, output port, output data, output button,
                  output pressed, input ready);
  modport sink (input valid, input op, input port, input data, input button,
                input pressed, output ready);
endinterface

@@ hdl/aiss_rsp_if.sv @@
// Result channel: read data and sound pulses, one item per request.
interface aiss_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_hit;
  logic [8:0] sound_trigger;
  logic       loop_start;
  logic       loop_stop;

  modport source (output valid, output read_data, output read_hit, output sound_trigger,
                  output loop_start, output loop_stop, input ready);
  modport sink (input valid, input read_data, input read_hit, input sound_trigger,
                input loop_start, input loop_stop, output ready);
endinterface

@@ hdl/aiss_in_stage.sv @@
// Input register that captures one request item and hands it to the core.
module aiss_in_stage (
  input  logic          clk,
  input  logic          rst,
  aiss_req_if.sink      req,
  output logic          stage_valid,
  output aiss_pkg::req_t stage_item,
  input  logic          core_ready
);

  logic take;

  assign req.ready = !stage_valid || core_ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
    if (take) begin
      stage_item.op      <= req.op;
      stage_item.port    <= req.port;
      stage_item.data    <= req.data;
      stage_item.button  <= req.button;
      stage_item.pressed <= req.pressed;
    end
  end

endmodule

@@ hdl/aiss_core.sv @@
// Port decode, shift register, button latches, sound edge detect and result register.
module aiss_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           stage_valid,
  input  aiss_pkg::req_t stage_item,
  output logic           core_ready,
  aiss_rsp_if.source     rsp
);

  logic [15:0] shift_word, shift_word_next;
  logic [2:0]  shift_amount, shift_amount_next;
  logic [7:0]  buttons_one, buttons_one_next;
  logic [7:0]  buttons_two, buttons_two_next;
  logic [7:0]  last_sound_a, last_sound_a_next;
  logic [7:0]  last_sound_b, last_sound_b_next;
  logic        loop_playing, loop_playing_next;

  aiss_pkg::rsp_t result, result_next;
  logic           out_valid;
  logic           advance;

  logic [15:0] shifted;
  logic [7:0]  diff_a, diff_b, mask_one, mask_two;

  assign core_ready = !out_valid || rsp.ready;
  assign advance    = stage_valid && core_ready;

  assign shifted  = shift_word >> (aiss_pkg::SHIFT_BASE - {1'b0, shift_amount});
  assign diff_a   = stage_item.data ^ last_sound_a;
  assign diff_b   = stage_item.data ^ last_sound_b;
  assign mask_one = aiss_pkg::btn_mask_one(stage_item.button);
  assign mask_two = aiss_pkg::btn_mask_two(stage_item.button);

  always_comb begin
    shift_word_next   = shift_word;
    shift_amount_next = shift_amount;
    buttons_one_next  = buttons_one;
    buttons_two_next  = buttons_two;
    last_sound_a_next = last_sound_a;
    last_sound_b_next = last_sound_b;
    loop_playing_next = loop_playing;
    result_next       = '0;

    unique case (aiss_pkg::op_t'(stage_item.op))
      aiss_pkg::OP_IN: begin
        result_next.read_hit = 1'b1;
        unique case (stage_item.port)
          aiss_pkg::PORT_ALL_ONES: result_next.read_data = aiss_pkg::ALL_ONES;
          aiss_pkg::PORT_BTN_ONE:  result_next.read_data = buttons_one;
          aiss_pkg::PORT_BTN_TWO:  result_next.read_data = buttons_two;
          aiss_pkg::PORT_SHIFT:    result_next.read_data = shifted[7:0];
          default:                 result_next.read_hit  = 1'b0;
        endcase
      end
      aiss_pkg::OP_OUT: begin
        unique case (stage_item.port)
          aiss_pkg::PORT_AMOUNT: shift_amount_next = stage_item.data[2:0];
          aiss_pkg::PORT_SHIFT_IN: shift_word_next = {stage_item.data, shift_word[15:8]};
          aiss_pkg::PORT_SOUND_A: begin
            // A change of bit 0 flips the looping sound between start and stop.
            if ((diff_a & aiss_pkg::LOOP_BIT) != 8'h00) begin
              loop_playing_next      = !loop_playing;
              result_next.loop_start = !loop_playing;
              result_next.loop_stop  = loop_playing;
            end
            result_next.sound_trigger = {1'b0, diff_a & aiss_pkg::SOUND_A_MASK};
            last_sound_a_next         = stage_item.data;
          end
          aiss_pkg::PORT_SOUND_B: begin
            result_next.sound_trigger = {diff_b[4:0] & aiss_pkg::SOUND_B_MASK[4:0], 4'h0};
            last_sound_b_next         = stage_item.data;
          end
          default: ;
        endcase
      end
      aiss_pkg::OP_BUTTON: begin
        if (stage_item.pressed) begin
          buttons_one_next = buttons_one | mask_one;
          buttons_two_next = buttons_two | mask_two;
        end else begin
          buttons_one_next = buttons_one & ~mask_one;
          buttons_two_next = buttons_two & ~mask_two;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word   <= '0;
      shift_amount <= '0;
      buttons_one  <= '0;
      buttons_two  <= '0;
      last_sound_a <= '0;
      last_sound_b <= '0;
      loop_playing <= 1'b0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      shift_word   <= shift_word_next;
      shift_amount <= shift_amount_next;
      buttons_one  <= buttons_one_next;
      buttons_two  <= buttons_two_next;
      last_sound_a <= last_sound_a_next;
      last_sound_b <= last_sound_b_next;
      loop_playing <= loop_playing_next;
      out_valid    <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = result.read_data;
  assign rsp.read_hit      = result.read_hit;
  assign rsp.sound_trigger = result.sound_trigger;
  assign rsp.loop_start    = result.loop_start;
  assign rsp.loop_stop     = result.loop_stop;

endmodule

@@ hdl/arcade_io_ports_shifter_sound_top.sv @@
// Top level of the arcade I/O board: input ports, barrel shifter and sound triggers.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, port, data, button, pressed
//   rsp      out  valid/ready   read_data, read_hit, sound_trigger, loop_start, loop_stop
//
// Every request gives exactly one result; the item passes the input register and then
// the result register, and is valid on rsp once it sits in the result register.
// A new request can be taken every cycle; the input register and the result
// register each hold one item, so a stalled result side fills both before req.ready drops.
// Synchronous reset clears the shift register, offset, button latches, last sound
// bytes and loop flag, and empties both registers.
module arcade_io_ports_shifter_sound_top (
  input  logic       clk,
  input  logic       rst,
  aiss_req_if.sink   req,
  aiss_rsp_if.source rsp
);

  logic           stage_valid;
  logic           core_ready;
  aiss_pkg::req_t stage_item;

  aiss_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .core_ready  (core_ready)
  );

  aiss_core u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .core_ready  (core_ready),
    .rsp         (rsp)
  );

`ifndef SYNTH
  // Input side only stalls when both registers are full behind a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (rsp.valid && !rsp.ready))
    else $error("request side stalled without a held result");

  a_loop_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.loop_start && rsp.loop_stop))
    else $error("loop start and stop in the same item");

  a_read_no_sound: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.read_hit) |-> (rsp.sound_trigger == 9'd0 && !rsp.loop_start
                                     && !rsp.loop_stop))
    else $error("read item carries sound pulses");

  a_trigger_bit0: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !rsp.sound_trigger[0])
    else $error("unused sound trigger bit set");
`endif

endmodule
